// File: hw/rtl/tbwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbwt_pkg;

  // Field widths.
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned DELAY_W  = 62;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned BUCKET_W = 64;

  // Tokens are kept as bytes times one billion.
  localparam int unsigned NS_PER_SEC_W = 30;
  localparam logic [NS_PER_SEC_W-1:0] NS_PER_SEC = 30'd1000000000;

  // The bucket holds at most two seconds of rate.
  localparam int unsigned TWO_SEC_W = 31;
  localparam logic [TWO_SEC_W-1:0] TWO_SEC_NS = 31'd2000000000;

  // Product widths.
  localparam int unsigned CAP_W     = TWO_SEC_W + RATE_W;
  localparam int unsigned NEED_W    = NS_PER_SEC_W + COUNT_W;
  localparam int unsigned REFILL_W  = TIME_W + RATE_W;

  // Divider widths.
  localparam int unsigned DIVIDEND_W = BUCKET_W;
  localparam int unsigned DIVISOR_W  = RATE_W;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ns;
    logic [COUNT_W-1:0] byte_count;
    logic               in_scope;
  } in_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay_ns;
    logic               throttled;
    logic [TOTAL_W-1:0] calls_total;
    logic [TOTAL_W-1:0] bytes_total;
    logic [TOTAL_W-1:0] throttled_total;
    logic [TOTAL_W-1:0] delay_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_REFILL,
    ST_TAKE,
    ST_DIV,
    ST_COUNT,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/tbwt_mul_serial.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add multiplier that consumes one multiplier bit per cycle.
module tbwt_mul_serial #(
  parameter int unsigned A_W = 32,
  parameter int unsigned B_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [A_W-1:0]     mcand,
  input  wire logic [B_W-1:0]     mplr,
  output logic                    done,
  output logic [A_W+B_W-1:0]      product
);

  localparam int unsigned CNT_W = $clog2(B_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

  logic [A_W+B_W-1:0] acc_r;
  logic [A_W-1:0]     mcand_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [A_W:0]       sum;
  logic [A_W+B_W-1:0] acc_nxt;

  // The low half holds the unused multiplier bits; the high half accumulates.
  always_comb begin
    sum     = {1'b0, acc_r[A_W+B_W-1:B_W]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
    acc_nxt = {sum, acc_r[B_W-1:1]};
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r   <= {{A_W{1'b0}}, mplr};
      mcand_r <= mcand;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/tbwt_div_serial.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that produces one quotient bit per cycle.
module tbwt_div_serial #(
  parameter int unsigned DVD_W = 64,
  parameter int unsigned DVS_W = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DVD_W-1:0]   dividend,
  input  wire logic [DVS_W-1:0]   divisor,
  output logic                    done,
  output logic [DVD_W-1:0]        quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/token_bucket_write_throttle.sv
// One request is worked on at a time. An active request runs the 32-step serial multipliers,
// and one that the bucket does not cover also the 64-step serial divider; a bypassed request
// skips the arithmetic. The output register lets a new request enter while the previous
// result waits. Reset is synchronous and clears the rate, bucket, timestamp and all totals;
// there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_write_throttle (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire tbwt_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output tbwt_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_wr_en,
  input  wire logic [tbwt_pkg::RATE_W-1:0]         cfg_wr_data
);

  tbwt_pkg::state_t state_r;
  tbwt_pkg::state_t state_nxt;

  logic [tbwt_pkg::RATE_W-1:0]   rate_r;
  logic [tbwt_pkg::RATE_W-1:0]   min_rate_r;
  logic [tbwt_pkg::BUCKET_W-1:0] bucket_r;
  logic [tbwt_pkg::TIME_W-1:0]   last_r;
  logic [tbwt_pkg::TOTAL_W-1:0]  calls_r;
  logic [tbwt_pkg::TOTAL_W-1:0]  bytes_r;
  logic [tbwt_pkg::TOTAL_W-1:0]  thr_r;
  logic [tbwt_pkg::TOTAL_W-1:0]  dly_r;
  logic [tbwt_pkg::DELAY_W-1:0]  delay_r;
  logic                          advance_r;
  tbwt_pkg::in_item_t            item_r;
  tbwt_pkg::out_item_t           out_item_r;
  logic                          out_valid_r;

  logic in_accept;
  logic active;
  logic mul_start;
  logic div_start;
  logic out_load;
  logic mul_done;

  logic [tbwt_pkg::TIME_W-1:0]     elapsed;
  logic                            advance;
  logic                            el_done;
  logic                            cap_done;
  logic                            capmin_done;
  logic                            need_done;
  logic [tbwt_pkg::REFILL_W-1:0]   el_prod;
  logic [tbwt_pkg::CAP_W-1:0]      cap_prod;
  logic [tbwt_pkg::CAP_W-1:0]      capmin_prod;
  logic [tbwt_pkg::NEED_W-1:0]     need_prod;
  logic [tbwt_pkg::BUCKET_W-1:0]   cap;
  logic [tbwt_pkg::BUCKET_W-1:0]   capmin;
  logic [tbwt_pkg::BUCKET_W-1:0]   need;
  logic [tbwt_pkg::BUCKET_W:0]     refill_sum;
  logic                            refill_ovf;
  logic [tbwt_pkg::BUCKET_W-1:0]   deficit;
  logic                            covered;
  logic                            div_done;
  logic [tbwt_pkg::DIVIDEND_W-1:0] div_quo;

  // Request decode at the input.
  always_comb begin
    in_accept = in_valid && !in_stall;
    active    = in_item.in_scope && (in_item.byte_count != '0) && (rate_r != '0);
    elapsed   = in_item.time_ns - last_r;
    advance   = in_item.time_ns > last_r;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbwt_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = active ? tbwt_pkg::ST_MUL : tbwt_pkg::ST_FIN;
        end
      end
      tbwt_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = tbwt_pkg::ST_CLAMP;
        end
      end
      tbwt_pkg::ST_CLAMP:  state_nxt = tbwt_pkg::ST_REFILL;
      tbwt_pkg::ST_REFILL: state_nxt = tbwt_pkg::ST_TAKE;
      tbwt_pkg::ST_TAKE: begin
        state_nxt = covered ? tbwt_pkg::ST_COUNT : tbwt_pkg::ST_DIV;
      end
      tbwt_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = tbwt_pkg::ST_COUNT;
        end
      end
      tbwt_pkg::ST_COUNT: state_nxt = tbwt_pkg::ST_FIN;
      tbwt_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = tbwt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tbwt_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the state machine.
  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      tbwt_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        mul_start = in_valid && active;
      end
      tbwt_pkg::ST_TAKE: div_start = !covered;
      tbwt_pkg::ST_FIN:  out_load  = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Serial products: refill amount, current cap, lowest cap since the last
  // request, and the request cost.
  tbwt_mul_serial #(
    .A_W(tbwt_pkg::TIME_W),
    .B_W(tbwt_pkg::RATE_W)
  ) u_mul_elapsed (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (elapsed),
    .mplr    (rate_r),
    .done    (el_done),
    .product (el_prod)
  );

  tbwt_mul_serial #(
    .A_W(tbwt_pkg::TWO_SEC_W),
    .B_W(tbwt_pkg::RATE_W)
  ) u_mul_cap (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (tbwt_pkg::TWO_SEC_NS),
    .mplr    (rate_r),
    .done    (cap_done),
    .product (cap_prod)
  );

  tbwt_mul_serial #(
    .A_W(tbwt_pkg::TWO_SEC_W),
    .B_W(tbwt_pkg::RATE_W)
  ) u_mul_capmin (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (tbwt_pkg::TWO_SEC_NS),
    .mplr    (min_rate_r),
    .done    (capmin_done),
    .product (capmin_prod)
  );

  tbwt_mul_serial #(
    .A_W(tbwt_pkg::NS_PER_SEC_W),
    .B_W(tbwt_pkg::COUNT_W)
  ) u_mul_need (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (tbwt_pkg::NS_PER_SEC),
    .mplr    (in_item.byte_count),
    .done    (need_done),
    .product (need_prod)
  );

  assign mul_done = el_done && cap_done && capmin_done && need_done;

  // Bucket arithmetic on the finished products.
  always_comb begin
    cap        = {1'b0, cap_prod};
    capmin     = {1'b0, capmin_prod};
    need       = {2'b00, need_prod};
    refill_sum = {1'b0, bucket_r} + {1'b0, el_prod[tbwt_pkg::BUCKET_W-1:0]};
    refill_ovf = (el_prod[tbwt_pkg::REFILL_W-1:tbwt_pkg::BUCKET_W] != '0)
                 || refill_sum[tbwt_pkg::BUCKET_W];
    covered    = bucket_r >= need;
    deficit    = need - bucket_r;
  end

  // Wait time is the deficit divided by the rate.
  tbwt_div_serial #(
    .DVD_W(tbwt_pkg::DIVIDEND_W),
    .DVS_W(tbwt_pkg::DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (deficit),
    .divisor  (rate_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // State register and rate config. The user writes config only while idle; the block does
  // not enforce it. The bucket clamp to the lowest written cap is applied at the next request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tbwt_pkg::ST_IDLE;
      rate_r     <= '0;
      min_rate_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        rate_r <= cfg_wr_data;
        if (cfg_wr_data < min_rate_r) begin
          min_rate_r <= cfg_wr_data;
        end
      end else if (state_r == tbwt_pkg::ST_CLAMP) begin
        min_rate_r <= rate_r;
      end
    end
  end

  // Bucket, timestamp and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r <= '0;
      last_r   <= '0;
      calls_r  <= '0;
      bytes_r  <= '0;
      thr_r    <= '0;
      dly_r    <= '0;
    end else begin
      case (state_r)
        tbwt_pkg::ST_CLAMP: begin
          if (bucket_r > capmin) begin
            bucket_r <= capmin;
          end
        end
        tbwt_pkg::ST_REFILL: begin
          if (advance_r) begin
            last_r <= item_r.time_ns;
            if (refill_ovf || (refill_sum[tbwt_pkg::BUCKET_W-1:0] > cap)) begin
              bucket_r <= cap;
            end else begin
              bucket_r <= refill_sum[tbwt_pkg::BUCKET_W-1:0];
            end
          end
        end
        tbwt_pkg::ST_TAKE: begin
          bucket_r <= covered ? (bucket_r - need) : '0;
        end
        tbwt_pkg::ST_COUNT: begin
          calls_r <= calls_r + 1'b1;
          bytes_r <= bytes_r + {{(tbwt_pkg::TOTAL_W - tbwt_pkg::COUNT_W){1'b0}},
                                item_r.byte_count};
          if (delay_r != '0) begin
            thr_r <= thr_r + 1'b1;
            dly_r <= dly_r + {{(tbwt_pkg::TOTAL_W - tbwt_pkg::DELAY_W){1'b0}}, delay_r};
          end
        end
        default: begin
          bucket_r <= bucket_r;
        end
      endcase
    end
  end

  // Captured request and its delay.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r    <= in_item;
      advance_r <= advance;
      delay_r   <= '0;
    end else if ((state_r == tbwt_pkg::ST_TAKE) && covered) begin
      delay_r <= '0;
    end else if ((state_r == tbwt_pkg::ST_DIV) && div_done) begin
      delay_r <= div_quo[tbwt_pkg::DELAY_W-1:0];
    end
  end

  // Output register; the result transaction holds until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.delay_ns        <= delay_r;
      out_item_r.throttled       <= delay_r != '0;
      out_item_r.calls_total     <= calls_r;
      out_item_r.bytes_total     <= bytes_r;
      out_item_r.throttled_total <= thr_r;
      out_item_r.delay_total     <= dly_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// File: hw/rtl/tbwt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks for the write throttle.
module tbwt_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tbwt_pkg::out_item_t out_item
);

  // Reset leaves no result transaction pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a request is in progress");

  // The throttled flag follows the delay.
  a_throttled_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.throttled == (out_item.delay_ns != '0)))
    else $error("throttled flag disagrees with delay");

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

endmodule

bind token_bucket_write_throttle tbwt_checker u_tbwt_checker (.*);

`default_nettype wire

// File: bench/token_bucket_write_throttle_tb.sv
`timescale 1ns / 1ps

module token_bucket_write_throttle_tb;

  localparam int RX_HOLD_CYCLES = 400;
  localparam logic [tbwt_pkg::TIME_W-1:0] TIME_MAX = {tbwt_pkg::TIME_W{1'b1}};
  localparam logic [tbwt_pkg::COUNT_W-1:0] COUNT_MAX = {tbwt_pkg::COUNT_W{1'b1}};
  localparam logic [tbwt_pkg::RATE_W-1:0] RATE_MAX = {tbwt_pkg::RATE_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tbwt_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tbwt_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [tbwt_pkg::RATE_W-1:0] cfg_wr_data = '0;

  // Throttle state as the block should hold it.
  logic [tbwt_pkg::RATE_W-1:0] rate_cfg = '0;
  bit [63:0] bucket_tokens = '0;
  bit [63:0] refill_stamp = '0;
  bit [63:0] call_total = '0;
  bit [63:0] byte_total = '0;
  bit [63:0] throttle_total = '0;
  bit [63:0] delay_sum = '0;

  // Results still owed by the block, oldest first.
  tbwt_pkg::out_item_t due_results[$];

  // Request time that the stimulus moves forward.
  logic [tbwt_pkg::TIME_W-1:0] req_clock = '0;

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_ticket = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;

  int fail_count = 0;
  int writes_sent = 0;
  int results_checked = 0;
  int throttled_seen = 0;
  int rate_settings = 0;

  token_bucket_write_throttle uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Apply one write request to the bucket and return the result it should produce.
  function automatic tbwt_pkg::out_item_t throttle_request(tbwt_pkg::in_item_t req);
    tbwt_pkg::out_item_t res;
    bit [63:0] now, cap, need, elapsed, deficit, wait_ns;
    bit [127:0] refill;
    bit [64:0] sum;
    now = 64'(req.time_ns);
    wait_ns = '0;
    if (req.in_scope && req.byte_count != 0 && rate_cfg != 0) begin
      cap = 64'(rate_cfg) * 64'd2_000_000_000;
      need = 64'(req.byte_count) * 64'd1_000_000_000;
      // Refill only when time has moved forward; any overflow lands on the cap.
      if (now > refill_stamp) begin
        elapsed = now - refill_stamp;
        refill = 128'(elapsed) * 128'(rate_cfg);
        sum = 65'(bucket_tokens) + 65'(refill[63:0]);
        if (refill[127:64] != 0 || sum[64] || sum[63:0] > cap)
          bucket_tokens = cap;
        else
          bucket_tokens = sum[63:0];
        refill_stamp = now;
      end
      call_total += 1;
      byte_total += 64'(req.byte_count);
      // Take the bytes, or empty the bucket and charge the shortfall as a wait.
      if (bucket_tokens >= need) begin
        bucket_tokens -= need;
      end else begin
        deficit = need - bucket_tokens;
        bucket_tokens = '0;
        wait_ns = deficit / 64'(rate_cfg);
        wait_ns[63:62] = 2'b00;
        if (wait_ns != 0) begin
          throttle_total += 1;
          delay_sum += wait_ns;
        end
      end
    end
    res = '0;
    res.delay_ns = wait_ns[tbwt_pkg::DELAY_W-1:0];
    res.throttled = (wait_ns != 0);
    res.calls_total = call_total;
    res.bytes_total = byte_total;
    res.throttled_total = throttle_total;
    res.delay_total = delay_sum;
    return res;
  endfunction

  function automatic tbwt_pkg::in_item_t make_write(logic [tbwt_pkg::TIME_W-1:0] t,
                                                    logic [tbwt_pkg::COUNT_W-1:0] n,
                                                    logic scope);
    tbwt_pkg::in_item_t req;
    req.time_ns = t;
    req.byte_count = n;
    req.in_scope = scope;
    return req;
  endfunction

  function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Offer one request, after a random gap when tx_idle_en is set, and record its result once accepted.
  task automatic send_write(input tbwt_pkg::in_item_t req);
    int gap;
    gap = 0;
    if (tx_idle_en)
      while ($urandom_range(99) < 34) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_results.push_back(throttle_request(req));
    writes_sent++;
  endtask

  // Stop offering and wait until every owed result has been returned.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Rate writes happen only with the block idle; the bucket clamps to the new cap.
  task automatic set_rate(input logic [tbwt_pkg::RATE_W-1:0] rate);
    bit [63:0] cap;
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rate_cfg = rate;
    cap = 64'(rate) * 64'd2_000_000_000;
    if (bucket_tokens > cap) bucket_tokens = cap;
    rate_settings++;
  endtask

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  always @(posedge clk) begin
    if (rx_hold_seen != rx_hold_ticket) begin
      rx_hold_seen = rx_hold_ticket;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_en && ($urandom_range(99) < 34);
    end
  end

  // Compare each returned transaction with the oldest owed result.
  always @(posedge clk) begin
    tbwt_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected, expected none, actual delay %0d", $time,
                 out_item.delay_ns);
      end else begin
        want = due_results.pop_front();
        check_field("delay_ns", 64'(want.delay_ns), 64'(out_item.delay_ns));
        check_field("throttled", 64'(want.throttled), 64'(out_item.throttled));
        check_field("calls_total", want.calls_total, out_item.calls_total);
        check_field("bytes_total", want.bytes_total, out_item.bytes_total);
        check_field("throttled_total", want.throttled_total, out_item.throttled_total);
        check_field("delay_total", want.delay_total, out_item.delay_total);
        results_checked++;
        if (out_item.throttled === 1'b1) throttled_seen++;
      end
    end
  end

  // With the rate still at its reset value of zero, every request passes through.
  task automatic test_disabled_rate();
    send_write(make_write(63'd100, COUNT_MAX, 1'b1));
    send_write(make_write(63'd0, 32'd1, 1'b1));
  endtask

  // Refill, covered takes, bypasses, time going backwards and a large shortfall.
  task automatic test_refill_and_shortfall();
    set_rate(32'd1000);
    send_write(make_write(63'd0, 32'd1, 1'b1));
    send_write(make_write(63'd1_000_000_000, 32'd500, 1'b0));
    send_write(make_write(63'd1_000_000_000, 32'd0, 1'b1));
    send_write(make_write(63'd1_000_000_000, 32'd500, 1'b1));
    send_write(make_write(63'd999_999_995, 32'd400, 1'b1));
    send_write(make_write(63'd1_000_000_000, COUNT_MAX, 1'b1));
    send_write(make_write(63'd10_000_000_000, 32'd1, 1'b1));
    req_clock = 63'd10_000_000_000;
  endtask

  // Lowest rate, a shortfall below one rate unit, and refill overflow at the top rate.
  task automatic test_rate_extremes();
    set_rate(32'd1);
    req_clock += 63'd1_000_000_000;
    send_write(make_write(req_clock, COUNT_MAX, 1'b1));
    set_rate(32'd3);
    send_write(make_write(req_clock, 32'd1, 1'b1));
    // A deficit of one token is less than the rate, so the wait rounds down to zero.
    req_clock += 63'd333_333_333;
    send_write(make_write(req_clock, 32'd1, 1'b1));
    set_rate(RATE_MAX);
    req_clock += 63'd4_000_000_000;
    send_write(make_write(req_clock, 32'd1, 1'b1));
    // Bucket plus refill overflows 64 bits.
    req_clock += 63'd4_000_000_000;
    send_write(make_write(req_clock, 32'd1, 1'b1));
    // The refill product itself overflows.
    req_clock += 63'd5_000_000_000;
    send_write(make_write(req_clock, 32'd1, 1'b1));
    send_write(make_write(req_clock, COUNT_MAX, 1'b1));
  endtask

  // Lowering the rate clamps the bucket; a zero rate empties it.
  task automatic test_rate_write_clamp();
    set_rate(32'd1000);
    send_write(make_write(req_clock, 32'd2000, 1'b1));
    req_clock += 63'd5_000_000_000;
    send_write(make_write(req_clock, 32'd1, 1'b1));
    set_rate(32'd0);
    send_write(make_write(req_clock, 32'd1, 1'b1));
    set_rate(32'd1000);
    send_write(make_write(req_clock, 32'd1, 1'b1));
  endtask

  // Mostly forward-moving requests of log-spread sizes, with bypasses and stale times mixed in.
  task automatic run_random_writes(input logic [tbwt_pkg::RATE_W-1:0] rate, input int n);
    int pick;
    bit [63:0] step;
    logic [tbwt_pkg::TIME_W-1:0] t;
    logic [tbwt_pkg::COUNT_W-1:0] cnt;
    set_rate(rate);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      step = 64'($urandom) >> $urandom_range(0, 31);
      cnt = 32'($urandom >> $urandom_range(0, 31));
      if (pick < 8) begin
        t = tbwt_pkg::TIME_W'({$urandom, $urandom});
        send_write(make_write(t, $urandom, 1'b0));
      end else if (pick < 13) begin
        t = tbwt_pkg::TIME_W'({$urandom, $urandom});
        send_write(make_write(t, 32'd0, 1'b1));
      end else if (pick < 21) begin
        t = (step[tbwt_pkg::TIME_W-1:0] > req_clock) ? '0 :
            req_clock - step[tbwt_pkg::TIME_W-1:0];
        send_write(make_write(t, cnt, 1'b1));
      end else begin
        req_clock += step[tbwt_pkg::TIME_W-1:0];
        send_write(make_write(req_clock, cnt, 1'b1));
      end
    end
  endtask

  task automatic test_random_rates();
    run_random_writes(32'd1, 150);
    run_random_writes(RATE_MAX, 250);
    run_random_writes($urandom, 250);
    run_random_writes($urandom_range(1, 100_000), 250);
    run_random_writes(32'd0, 30);
  endtask

  // The receiver holds off long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    set_rate($urandom_range(1000, 1_000_000));
    tx_idle_en = 1'b0;
    rx_hold_ticket++;
    for (int i = 0; i < 30; i++) begin
      req_clock += tbwt_pkg::TIME_W'($urandom_range(0, 5_000_000));
      send_write(make_write(req_clock, $urandom_range(1, 20_000), 1'b1));
    end
    tx_idle_en = 1'b1;
    wait_drain();
  endtask

  // Back-to-back traffic on both sides.
  task automatic test_no_idle_stretch();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random_writes($urandom_range(1000, 50_000_000), 500);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Request times climbing to the top of the time range.
  task automatic test_time_ceiling();
    set_rate($urandom);
    req_clock = TIME_MAX - 63'd20_000_000_000;
    for (int i = 0; i < 14; i++) begin
      req_clock += tbwt_pkg::TIME_W'($urandom_range(0, 1_000_000_000));
      send_write(make_write(req_clock, 32'($urandom >> $urandom_range(0, 31)), 1'b1));
    end
    send_write(make_write(TIME_MAX, COUNT_MAX, 1'b1));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_rate();
    test_refill_and_shortfall();
    test_rate_extremes();
    test_rate_write_clamp();
    test_random_rates();
    test_output_backpressure();
    test_no_idle_stretch();
    test_time_ceiling();
    wait_drain();
    repeat (150) @(posedge clk);
    $display("Sent %0d write requests across %0d rate settings.", writes_sent, rate_settings);
    $display("Checked %0d results, %0d of them throttled.", results_checked, throttled_seen);
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("token_bucket_write_throttle test passed");
    end else begin
      $display("token_bucket_write_throttle test failed");
    end
    $finish;
  end

  // Give up if the run stalls.
  initial begin
    #20_000_000;
    $display("token_bucket_write_throttle test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tbwt_pkg.sv
hw/rtl/tbwt_mul_serial.sv
hw/rtl/tbwt_div_serial.sv
hw/rtl/token_bucket_write_throttle.sv
hw/rtl/tbwt_checker.sv
bench/token_bucket_write_throttle_tb.sv
